### rtl/quaternion_to_rotation_matrix_unit_defines.svh
// assertion macros shared by the converter modules
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define Q2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q2r assertion failed");

// next-cycle implication, checked out of reset
`define Q2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q2r assertion failed");

`else

`define Q2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define Q2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/q2r_pkg.sv
// constants shared by the quaternion to rotation matrix converter
package q2r_pkg;

    localparam int NUM_ENTRIES = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // diagonal entry positions in row-major order
    localparam int ENTRY_M00 = 0;
    localparam int ENTRY_M11 = 4;
    localparam int ENTRY_M22 = 8;

endpackage

### rtl/q2r_if.sv
// valid/ready channel interfaces of the converter

interface q2r_quat_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] qx;
    logic signed [DATA_WIDTH-1:0] qy;
    logic signed [DATA_WIDTH-1:0] qz;
    logic signed [DATA_WIDTH-1:0] qw;

    modport source (output valid, qx, qy, qz, qw, input ready);
    modport sink (input valid, qx, qy, qz, qw, output ready);
endinterface

interface q2r_mat_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic                         zero_norm;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  output ready);
endinterface

interface q2r_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### rtl/q2r_front.sv
// front end: zero check, halving, products and division operands
module q2r_front #(
    parameter int DATA_WIDTH = 16,
    parameter int NW         = 2 * DATA_WIDTH,
    parameter int EW         = 10 * NW + 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    q2r_quat_if.sink            i_quat,
    q2r_stream_if.source        o_ent
);
    logic fe;

    // stage a: conditioned components
    logic                         r_va;
    logic                         r_za;
    logic signed [DATA_WIDTH-1:0] r_xa, r_ya, r_za_q, r_wa;
    logic                         all_even;

    // stage b: products
    logic                 r_vb, r_zb;
    logic signed [NW-1:0] r_pxx, r_pyy, r_pzz, r_pww;
    logic signed [NW-1:0] r_pxy, r_pzw, r_pxz, r_pyw, r_pyz, r_pxw;
    logic signed [NW-1:0] xe, ye, ze, we;

    // stage c: sums and differences
    logic                 r_vc, r_zc;
    logic [NW-1:0]        r_swx, r_syz, r_swy, r_sxz, r_swz, r_sxy;
    logic signed [NW:0]   r_d01, r_d02, r_d10, r_d12, r_d20, r_d21;

    logic [NW-1:0]        n_sum;
    logic [NW-1:0]        mag [q2r_pkg::NUM_ENTRIES];
    logic [q2r_pkg::NUM_ENTRIES-1:0] neg;
    logic [EW-1:0]        ent;

    assign fe           = !r_vc || o_ent.ready;
    assign i_quat.ready = fe;
    assign all_even     = !(i_quat.qx[0] | i_quat.qy[0] | i_quat.qz[0] | i_quat.qw[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (fe) begin
            r_va <= i_quat.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    assign xe = NW'(r_xa);
    assign ye = NW'(r_ya);
    assign ze = NW'(r_za_q);
    assign we = NW'(r_wa);

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_za <= (i_quat.qx == '0) && (i_quat.qy == '0) &&
                    (i_quat.qz == '0) && (i_quat.qw == '0);
            r_xa   <= all_even ? (i_quat.qx >>> 1) : i_quat.qx;
            r_ya   <= all_even ? (i_quat.qy >>> 1) : i_quat.qy;
            r_za_q <= all_even ? (i_quat.qz >>> 1) : i_quat.qz;
            r_wa   <= all_even ? (i_quat.qw >>> 1) : i_quat.qw;

            r_zb  <= r_za;
            r_pxx <= xe * xe;
            r_pyy <= ye * ye;
            r_pzz <= ze * ze;
            r_pww <= we * we;
            r_pxy <= xe * ye;
            r_pzw <= ze * we;
            r_pxz <= xe * ze;
            r_pyw <= ye * we;
            r_pyz <= ye * ze;
            r_pxw <= xe * we;

            r_zc  <= r_zb;
            r_swx <= r_pww + r_pxx;
            r_syz <= r_pyy + r_pzz;
            r_swy <= r_pww + r_pyy;
            r_sxz <= r_pxx + r_pzz;
            r_swz <= r_pww + r_pzz;
            r_sxy <= r_pxx + r_pyy;
            r_d01 <= (NW+1)'(r_pxy) - (NW+1)'(r_pzw);
            r_d02 <= (NW+1)'(r_pxz) + (NW+1)'(r_pyw);
            r_d10 <= (NW+1)'(r_pxy) + (NW+1)'(r_pzw);
            r_d12 <= (NW+1)'(r_pyz) - (NW+1)'(r_pxw);
            r_d20 <= (NW+1)'(r_pxz) - (NW+1)'(r_pyw);
            r_d21 <= (NW+1)'(r_pyz) + (NW+1)'(r_pxw);
        end
    end

    // magnitude and sign of each numerator
    function automatic logic [NW:0] diag_op(input logic [NW-1:0] p, input logic [NW-1:0] q);
        logic ge;
        ge = (p >= q);
        return {!ge, ge ? (p - q) : (q - p)};
    endfunction

    function automatic logic [NW:0] offd_op(input logic signed [NW:0] d);
        logic [NW:0] a;
        a = d[NW] ? (NW+1)'(-d) : (NW+1)'(d);
        return {d[NW], a[NW-2:0], 1'b0};
    endfunction

    always_comb begin
        logic [NW:0] t [q2r_pkg::NUM_ENTRIES];
        n_sum = r_swx + r_syz;
        t[0] = diag_op(r_swx, r_syz);
        t[1] = offd_op(r_d01);
        t[2] = offd_op(r_d02);
        t[3] = offd_op(r_d10);
        t[4] = diag_op(r_swy, r_sxz);
        t[5] = offd_op(r_d12);
        t[6] = offd_op(r_d20);
        t[7] = offd_op(r_d21);
        t[8] = diag_op(r_swz, r_sxy);
        ent = '0;
        ent[NW-1:0] = n_sum;
        for (int j = 0; j < q2r_pkg::NUM_ENTRIES; j++) begin
            mag[j] = t[j][NW-1:0];
            neg[j] = t[j][NW];
            ent[NW*(j+1) +: NW] = mag[j];
        end
        ent[10*NW +: q2r_pkg::NUM_ENTRIES] = neg;
        ent[EW-1] = r_zc;
    end

    assign o_ent.valid = r_vc;
    assign o_ent.data  = ent;

endmodule

### rtl/q2r_queue.sv
// short queue between front end and divider back end
`include "quaternion_to_rotation_matrix_unit_defines.svh"
module q2r_queue #(
    parameter int WIDTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    q2r_stream_if.sink   i_ent,
    q2r_stream_if.source o_ent
);
    logic [WIDTH-1:0]                  r_mem [q2r_pkg::QUEUE_DEPTH];
    logic [q2r_pkg::QUEUE_PTR_W-1:0]   r_wr, r_rd;
    logic [q2r_pkg::QUEUE_CNT_W-1:0]   r_cnt;
    logic push, pop;

    assign i_ent.ready = (r_cnt != q2r_pkg::QUEUE_CNT_W'(q2r_pkg::QUEUE_DEPTH));
    assign o_ent.valid = (r_cnt != '0);
    assign o_ent.data  = r_mem[r_rd];
    assign push        = i_ent.valid && i_ent.ready;
    assign pop         = o_ent.valid && o_ent.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_ent.data;
    end

    `Q2R_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= q2r_pkg::QUEUE_CNT_W'(q2r_pkg::QUEUE_DEPTH))
    `Q2R_ASSERT_IMP(a_ptr_track, i_clk, i_rst_n, 1'b1, q2r_pkg::QUEUE_PTR_W'(r_rd + r_cnt) == r_wr)

endmodule

### rtl/q2r_back.sv
// back end: pipelined restoring dividers, rounding and saturation
`include "quaternion_to_rotation_matrix_unit_defines.svh"
module q2r_back #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int NW         = 2 * DATA_WIDTH,
    parameter int EW         = 10 * NW + 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    q2r_stream_if.sink   i_ent,
    q2r_mat_if.source    o_mat
);
    localparam int NE = q2r_pkg::NUM_ENTRIES;
    localparam int S  = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 2;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam longint MAX_L = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint LIM_L = (ONE_L < MAX_L) ? ONE_L : MAX_L;
    localparam logic [DATA_WIDTH-1:0] LIM = DATA_WIDTH'(LIM_L);

    logic be;
    logic                r_v    [S];
    logic                r_zero [S];
    logic [NE-1:0]       r_neg  [S];
    logic [NW-1:0]       r_n    [S];
    logic [NW-1:0]       r_rem  [S][NE];
    logic [QW-1:0]       r_quo  [S][NE];

    logic                  r_ov, r_zn;
    logic [DATA_WIDTH-1:0] r_m [NE];

    logic [NW-1:0] in_n;
    logic [NW-1:0] in_mag [NE];

    assign be          = !r_ov || o_mat.ready;
    assign i_ent.ready = be;
    assign in_n        = i_ent.data[NW-1:0];

    always_comb begin
        for (int j = 0; j < NE; j++) in_mag[j] = i_ent.data[NW*(j+1) +: NW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (be) begin
            r_v[0] <= i_ent.valid;
            for (int k = 1; k < S; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[S-1];
        end
    end

    // one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_n[0]    <= in_n;
            r_neg[0]  <= i_ent.data[10*NW +: NE];
            r_zero[0] <= i_ent.data[EW-1];
            for (int j = 0; j < NE; j++) begin
                r_quo[0][j] <= QW'(in_mag[j] >= in_n);
                r_rem[0][j] <= (in_mag[j] >= in_n) ? (in_mag[j] - in_n) : in_mag[j];
            end
            for (int k = 1; k < S; k++) begin
                r_n[k]    <= r_n[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                for (int j = 0; j < NE; j++) begin
                    logic [NW:0] rs;
                    logic        ge;
                    rs = {r_rem[k-1][j], 1'b0};
                    ge = (rs >= {1'b0, r_n[k-1]});
                    r_rem[k][j] <= ge ? NW'(rs - {1'b0, r_n[k-1]}) : NW'(rs);
                    r_quo[k][j] <= {r_quo[k-1][j][QW-2:0], ge};
                end
            end
        end
    end

    // round half away from zero, clamp, apply sign; a zero norm gives the identity
    always_ff @(posedge i_clk) begin
        if (be) begin
            r_zn <= r_zero[S-1];
            for (int j = 0; j < NE; j++) begin
                logic [QW:0]           rnd;
                logic [DATA_WIDTH-1:0] sat;
                rnd = ({1'b0, r_quo[S-1][j]} + 1'b1) >> 1;
                sat = (64'(rnd) > 64'(LIM_L)) ? LIM : DATA_WIDTH'(rnd);
                if (r_zero[S-1]) begin
                    r_m[j] <= (j == q2r_pkg::ENTRY_M00 || j == q2r_pkg::ENTRY_M11 ||
                               j == q2r_pkg::ENTRY_M22) ? LIM : '0;
                end else begin
                    r_m[j] <= r_neg[S-1][j] ? DATA_WIDTH'(-sat) : sat;
                end
            end
        end
    end

    assign o_mat.valid     = r_ov;
    assign o_mat.zero_norm = r_zn;
    assign o_mat.m00       = r_m[0];
    assign o_mat.m01       = r_m[1];
    assign o_mat.m02       = r_m[2];
    assign o_mat.m10       = r_m[3];
    assign o_mat.m11       = r_m[4];
    assign o_mat.m12       = r_m[5];
    assign o_mat.m20       = r_m[6];
    assign o_mat.m21       = r_m[7];
    assign o_mat.m22       = r_m[8];

    `Q2R_ASSERT_IMP(a_zero_identity, i_clk, i_rst_n, o_mat.valid && o_mat.zero_norm, o_mat.m00 == LIM && o_mat.m01 == '0 && o_mat.m22 == LIM)

endmodule

### rtl/quaternion_to_rotation_matrix_unit.sv
// top level of the quaternion to rotation matrix converter
//
//  channel   dir   payload                         transfer when
//  i_quat    in    qx qy qz qw                     valid && ready
//  o_mat     out   m00..m22, zero_norm             valid && ready
//
// one quaternion per cycle is taken and one matrix per cycle is given while the output is not stalled
// path: front stages a to c, queue, divider stages, output register
// the divider pipeline (one quotient bit per stage, nine lanes) sets the depth
// synchronous active-low reset empties all stages and the queue
// a 4-entry queue lets the front end keep taking items while the output stalls, until it is full
module quaternion_to_rotation_matrix_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    q2r_quat_if.sink  i_quat,
    q2r_mat_if.source o_mat
);
    // squared norm and numerators are twice the input width
    localparam int NW = 2 * DATA_WIDTH;
    // queue entry: norm, nine magnitudes, nine signs, zero flag
    localparam int EW = 10 * NW + 10;

    q2r_stream_if #(.WIDTH(EW)) front_to_q ();
    q2r_stream_if #(.WIDTH(EW)) q_to_back ();

    // front end: condition input, form products and division operands
    q2r_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .NW         (NW),
        .EW         (EW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (i_quat),
        .o_ent   (front_to_q)
    );

    // decoupling queue
    q2r_queue #(
        .WIDTH (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ent   (front_to_q),
        .o_ent   (q_to_back)
    );

    // back end: nine divider lanes and output register
    q2r_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .NW         (NW),
        .EW         (EW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ent   (q_to_back),
        .o_mat   (o_mat)
    );

endmodule
